// ===== rtl/hciuart_pkg.sv =====
// Shared types and constants for the HCI UART H4 receive deframer.
// No dependencies.
package hciuart_pkg;

  // H4 packet type bytes
  localparam logic [7:0] TYPE_ACL = 8'h02;
  localparam logic [7:0] TYPE_EVT = 8'h04;

  // packet kind as carried on pkt_kind
  localparam logic KIND_EVT = 1'b0;
  localparam logic KIND_ACL = 1'b1;

  // deframer phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // configuration register index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_PRIO_A = 2'd0,
    REG_PRIO_B = 2'd1,
    REG_PRIO_C = 2'd2,
    REG_PRIO_D = 2'd3
  } reg_idx_t;

  // header byte positions
  localparam logic [1:0] HDR_FIRST   = 2'd0;
  localparam logic [1:0] HDR_EVT_LEN = 2'd1;
  localparam logic [1:0] HDR_ACL_LLO = 2'd2;
  localparam logic [1:0] HDR_ACL_LHI = 2'd3;

endpackage

// ===== rtl/hci_uart_h4_rx_deframer.sv =====
// HCI UART H4 receive deframer: input word register, deframing logic, result register.
// Each word waits in the input register; any result goes to the result register.
// Throughput: one word per cycle (one deframing step each) while out_stall is low.
// Reset (rst, synchronous, active high): pipeline empty, waiting for a type byte,
// priority codes at 14, 15, 19 and 26.
// Depends on hciuart_pkg.
module hci_uart_h4_rx_deframer (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        pkt_kind,
  output logic        first_byte,
  output logic        last_byte,
  output logic        priority_res,
  output logic        bad_type,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hciuart_pkg::*;

  // configuration registers
  logic [7:0] prio_code_a, prio_code_b, prio_code_c, prio_code_d;
  reg_idx_t   cfg_idx;

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // deframer state
  phase_t     phase, phase_next;
  logic       kind_reg, kind_reg_next;
  logic [1:0] hdr_index, hdr_index_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0] len_low, len_low_next;
  logic       prio_reg, prio_reg_next;

  // step results
  logic       advance, proc;
  logic       res_valid, res_first, res_last, res_prio, res_bad, res_kind;
  logic       code_hit, final_hdr;
  logic [15:0] hdr_len, left_dec;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prio_code_a <= 8'd14;
      prio_code_b <= 8'd15;
      prio_code_c <= 8'd19;
      prio_code_d <= 8'd26;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_PRIO_A: prio_code_a <= pwdata[7:0];
        REG_PRIO_B: prio_code_b <= pwdata[7:0];
        REG_PRIO_C: prio_code_c <= pwdata[7:0];
        REG_PRIO_D: prio_code_d <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      REG_PRIO_A: prdata = {24'd0, prio_code_a};
      REG_PRIO_B: prdata = {24'd0, prio_code_b};
      REG_PRIO_C: prdata = {24'd0, prio_code_c};
      REG_PRIO_D: prdata = {24'd0, prio_code_d};
      default:    prdata = 32'd0;
    endcase
  end

  // the input register moves on when the result register is free or drains
  assign advance  = !out_valid || !out_stall;
  assign proc     = in_full && advance;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // deframing step on the held word
  assign code_hit = (in_byte == prio_code_a) || (in_byte == prio_code_b) ||
                    (in_byte == prio_code_c) || (in_byte == prio_code_d);
  assign left_dec = bytes_left - 16'd1;
  assign hdr_len  = (kind_reg == KIND_EVT) ? {8'd0, in_byte} : {in_byte, len_low};

  always_comb begin
    phase_next      = phase;
    kind_reg_next   = kind_reg;
    hdr_index_next  = hdr_index;
    bytes_left_next = bytes_left;
    len_low_next    = len_low;
    prio_reg_next   = prio_reg;
    res_valid       = 1'b0;
    res_first       = 1'b0;
    res_last        = 1'b0;
    res_prio        = 1'b0;
    res_bad         = 1'b0;
    res_kind        = 1'b0;
    final_hdr       = 1'b0;
    case (phase)
      PH_HEADER: begin
        res_valid = 1'b1;
        res_kind  = kind_reg;
        res_first = (hdr_index == HDR_FIRST);
        res_prio  = prio_reg;
        if (kind_reg == KIND_EVT) begin
          if (hdr_index == HDR_FIRST) begin
            prio_reg_next = code_hit;
            res_prio      = code_hit;
          end else begin
            final_hdr = 1'b1;
          end
        end else begin
          if (hdr_index == HDR_ACL_LLO) begin
            len_low_next = in_byte;
          end else if (hdr_index == HDR_ACL_LHI) begin
            final_hdr = 1'b1;
          end
        end
        if (final_hdr) begin
          bytes_left_next = hdr_len;
          hdr_index_next  = HDR_FIRST;
          if (hdr_len == 16'd0) begin
            res_last   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          hdr_index_next = hdr_index + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        res_valid       = 1'b1;
        res_kind        = kind_reg;
        res_prio        = prio_reg;
        bytes_left_next = left_dec;
        if (left_dec == 16'd0) begin
          res_last       = 1'b1;
          phase_next     = PH_IDLE;
          hdr_index_next = HDR_FIRST;
        end
      end
      default: begin
        // waiting for a type byte
        hdr_index_next = HDR_FIRST;
        if (in_byte == TYPE_EVT || in_byte == TYPE_ACL) begin
          kind_reg_next   = (in_byte == TYPE_ACL) ? KIND_ACL : KIND_EVT;
          prio_reg_next   = 1'b0;
          phase_next      = PH_HEADER;
          bytes_left_next = 16'd0;
        end else begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          res_bad    = 1'b1;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      kind_reg   <= 1'b0;
      hdr_index  <= HDR_FIRST;
      bytes_left <= 16'd0;
      len_low    <= 8'd0;
      prio_reg   <= 1'b0;
    end else if (proc) begin
      phase      <= phase_next;
      kind_reg   <= kind_reg_next;
      hdr_index  <= hdr_index_next;
      bytes_left <= bytes_left_next;
      len_low    <= len_low_next;
      prio_reg   <= prio_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= res_valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_byte     <= in_byte;
      pkt_kind     <= res_kind;
      first_byte   <= res_first;
      last_byte    <= res_last;
      priority_res <= res_prio;
      bad_type     <= res_bad;
    end
  end

endmodule
